/* design/smoothed_sine_oscillator_macros.svh */
// Assertion macros used by the checker file sso_checker.sv.
`ifndef SMOOTHED_SINE_OSCILLATOR_MACROS_SVH
`define SMOOTHED_SINE_OSCILLATOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define SSO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define SSO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sso_pkg.sv */
`default_nettype none
package sso_pkg;

    localparam int SINE_TABLE_BITS = 8;
    localparam int SAMPLE_BITS     = 16;

    localparam int FREQ_W   = 23;
    localparam int AMP_W    = 16;
    localparam int SCALE_W  = 28;
    localparam int COEFF_W  = 16;
    localparam int PHASE_W  = 32;
    localparam int SINE_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 28;
    localparam int CFG_IDX_W = 3;

    localparam int MUL_A_W = SCALE_W;
    localparam int MUL_B_W = FREQ_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FRAC_W  = 16;
    localparam int AMP_FRAC_W = 15;

    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int ROM_IDX_W   = SINE_TABLE_BITS - 1;
    localparam int POS_W       = SINE_TABLE_BITS - 2;

    localparam int MAG_W = 16;
    localparam int SAT_W = ((SAMPLE_BITS > MAG_W) ? SAMPLE_BITS : MAG_W) + 2;
    localparam logic signed [SAT_W-1:0] SAT_HI =
        SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    localparam logic [FREQ_W-1:0]  RESET_FREQUENCY = FREQ_W'(112640);
    localparam logic [AMP_W-1:0]   RESET_AMPLITUDE = AMP_W'(16384);
    localparam logic [SCALE_W-1:0] RESET_SCALE     = SCALE_W'(22906492);
    localparam logic [COEFF_W-1:0] RESET_COEFF     = COEFF_W'(65399);

    localparam logic MODE_CONTROL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_FREQUENCY = 3'd0,
        CFG_DEFAULT_AMPLITUDE = 3'd1,
        CFG_PHASE_STEP_SCALE  = 3'd2,
        CFG_FREQ_SMOOTH_COEFF = 3'd3,
        CFG_AMP_SMOOTH_COEFF  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic              neg;
        logic [SINE_W-1:0] mag;
    } t_sine;

    typedef logic [SINE_W-1:0] t_sine_rom [0:QUARTER_LEN];

    localparam longint Q30 = 64'sd1073741824;

    // Quarter-wave sine from an odd ninth-order polynomial in Q30.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    t;
        longint    t2;
        longint    p;
        longint    s;
        longint    v;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            t  = longint'(k) <<< (32 - SINE_TABLE_BITS);
            t2 = (t * t) / Q30;
            p  = 64'sd172273;
            p  = -64'sd5026994 + (p * t2) / Q30;
            p  = 64'sd85569306 + (p * t2) / Q30;
            p  = -64'sd693598667 + (p * t2) / Q30;
            p  = 64'sd1686629713 + (p * t2) / Q30;
            s  = (t * p) / Q30;
            if (s < 0) begin
                s = 0;
            end
            v = (s * 32767 + (Q30 / 2)) / Q30;
            if (v > 32767) begin
                v = 32767;
            end
            rom[k] = SINE_W'(v);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

/* design/sso_mul.sv */
`default_nettype none
module sso_mul (
    input  wire                              i_clk,
    input  wire  [sso_pkg::MUL_A_W-1:0]      i_a,
    input  wire  [sso_pkg::MUL_B_W-1:0]      i_b,
    output logic [sso_pkg::PROD_W-1:0]       o_prod
);

    logic [sso_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= sso_pkg::PROD_W'(i_a) * sso_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

/* design/sso_sine.sv */
`default_nettype none
module sso_sine (
    input  wire                                  i_clk,
    input  wire  [sso_pkg::SINE_TABLE_BITS-1:0]  i_index,
    output sso_pkg::t_sine                       o_sine
);

    logic [1:0]                      w_quad;
    logic [sso_pkg::POS_W-1:0]       w_pos;
    logic [sso_pkg::ROM_IDX_W-1:0]   w_rom_idx;
    sso_pkg::t_sine                  r_sine;

    localparam logic [sso_pkg::ROM_IDX_W-1:0] QUARTER_IDX =
        sso_pkg::ROM_IDX_W'(sso_pkg::QUARTER_LEN);

    assign w_quad = i_index[sso_pkg::SINE_TABLE_BITS-1 -: 2];
    assign w_pos  = i_index[sso_pkg::POS_W-1:0];

    always_comb begin
        if (w_quad[0]) begin
            w_rom_idx = QUARTER_IDX - {1'b0, w_pos};
        end else begin
            w_rom_idx = {1'b0, w_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine.neg <= w_quad[1];
        r_sine.mag <= sso_pkg::SINE_ROM[w_rom_idx];
    end

    assign o_sine = r_sine;

endmodule
`default_nettype wire

/* design/smoothed_sine_oscillator.sv */
// A control item is taken without making the block busy and gives no result.
// A tick item occupies the shared multiplier for four products in a row and
// its sample is loaded into the output register as the block leaves ST_OUT.
// ST_OUT holds while the output stalls; controls are taken every cycle when idle.
// Synchronous active-low reset restores the register defaults, both goals and
// current values, and clears the phase, the phase step and the output register.
`default_nettype none
module smoothed_sine_oscillator (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_mode,
    input  wire                                i_freq_connected,
    input  wire  [sso_pkg::FREQ_W-1:0]         i_target_frequency,
    input  wire                                i_amp_connected,
    input  wire  [sso_pkg::AMP_W-1:0]          i_target_amplitude,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [sso_pkg::SAMPLE_W-1:0]       o_sample,
    input  wire                                i_cfg_we,
    input  wire  [sso_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [sso_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FUPD,
        ST_PMUL,
        ST_SMUL,
        ST_OUT
    } t_state;

    t_state r_state;

    logic [sso_pkg::FREQ_W-1:0]   r_def_freq;
    logic [sso_pkg::AMP_W-1:0]    r_def_amp;
    logic [sso_pkg::SCALE_W-1:0]  r_scale;
    logic [sso_pkg::COEFF_W-1:0]  r_freq_coeff;
    logic [sso_pkg::COEFF_W-1:0]  r_amp_coeff;

    logic [sso_pkg::FREQ_W-1:0]   r_cur_freq;
    logic [sso_pkg::FREQ_W-1:0]   r_goal_freq;
    logic [sso_pkg::AMP_W-1:0]    r_cur_amp;
    logic [sso_pkg::AMP_W-1:0]    r_goal_amp;
    logic [sso_pkg::PHASE_W-1:0]  r_phase_acc;
    logic [sso_pkg::PHASE_W-1:0]  r_phase_step;

    logic                         r_out_valid;
    logic [sso_pkg::SAMPLE_W-1:0] r_sample;

    logic                         w_freq_ge;
    logic                         w_amp_ge;
    logic [sso_pkg::FREQ_W-1:0]   w_freq_dist;
    logic [sso_pkg::AMP_W-1:0]    w_amp_dist;
    logic [sso_pkg::MUL_A_W-1:0]  w_mul_a;
    logic [sso_pkg::MUL_B_W-1:0]  w_mul_b;
    logic [sso_pkg::PROD_W-1:0]   w_prod;
    sso_pkg::t_sine               w_sine;

    logic [sso_pkg::FREQ_W-1:0]   w_freq_p;
    logic [sso_pkg::AMP_W-1:0]    w_amp_p;
    logic [sso_pkg::MAG_W-1:0]    w_mag;
    logic signed [sso_pkg::SAT_W-1:0] w_val;
    logic signed [sso_pkg::SAT_W-1:0] w_sat;

    logic [sso_pkg::FREQ_W-1:0]   n_cur_freq;
    logic [sso_pkg::AMP_W-1:0]    n_cur_amp;
    logic [sso_pkg::SAMPLE_W-1:0] n_sample;

    logic w_in_take;
    logic w_out_free;

    sso_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    sso_sine u_sine (
        .i_clk   (i_clk),
        .i_index (r_phase_acc[sso_pkg::PHASE_W-1 -: sso_pkg::SINE_TABLE_BITS]),
        .o_sine  (w_sine)
    );

    assign w_freq_ge   = (r_cur_freq >= r_goal_freq);
    assign w_amp_ge    = (r_cur_amp >= r_goal_amp);
    assign w_freq_dist = w_freq_ge ? (r_cur_freq - r_goal_freq) : (r_goal_freq - r_cur_freq);
    assign w_amp_dist  = w_amp_ge ? (r_cur_amp - r_goal_amp) : (r_goal_amp - r_cur_amp);

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                w_mul_a = sso_pkg::MUL_A_W'(r_freq_coeff);
                w_mul_b = w_freq_dist;
            end
            ST_FUPD: begin
                w_mul_a = sso_pkg::MUL_A_W'(r_amp_coeff);
                w_mul_b = sso_pkg::MUL_B_W'(w_amp_dist);
            end
            ST_PMUL: begin
                w_mul_a = r_scale;
                w_mul_b = r_cur_freq;
            end
            ST_SMUL, ST_OUT: begin
                w_mul_a = sso_pkg::MUL_A_W'(r_cur_amp);
                w_mul_b = sso_pkg::MUL_B_W'(w_sine.mag);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_freq_p = w_prod[sso_pkg::FRAC_W +: sso_pkg::FREQ_W];
    assign w_amp_p  = w_prod[sso_pkg::FRAC_W +: sso_pkg::AMP_W];
    assign w_mag    = w_prod[sso_pkg::AMP_FRAC_W +: sso_pkg::MAG_W];

    assign n_cur_freq = w_freq_ge ? (r_goal_freq + w_freq_p) : (r_goal_freq - w_freq_p);
    assign n_cur_amp  = w_amp_ge ? (r_goal_amp + w_amp_p) : (r_goal_amp - w_amp_p);

    always_comb begin
        if (w_sine.neg) begin
            w_val = -signed'(sso_pkg::SAT_W'(w_mag));
        end else begin
            w_val = signed'(sso_pkg::SAT_W'(w_mag));
        end
        if (w_val > sso_pkg::SAT_HI) begin
            w_sat = sso_pkg::SAT_HI;
        end else if (w_val < sso_pkg::SAT_LO) begin
            w_sat = sso_pkg::SAT_LO;
        end else begin
            w_sat = w_val;
        end
        n_sample = w_sat[sso_pkg::SAMPLE_W-1:0];
    end

    assign w_in_take  = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_def_freq   <= sso_pkg::RESET_FREQUENCY;
            r_def_amp    <= sso_pkg::RESET_AMPLITUDE;
            r_scale      <= sso_pkg::RESET_SCALE;
            r_freq_coeff <= sso_pkg::RESET_COEFF;
            r_amp_coeff  <= sso_pkg::RESET_COEFF;
            r_cur_freq   <= sso_pkg::RESET_FREQUENCY;
            r_goal_freq  <= sso_pkg::RESET_FREQUENCY;
            r_cur_amp    <= sso_pkg::RESET_AMPLITUDE;
            r_goal_amp   <= sso_pkg::RESET_AMPLITUDE;
            r_phase_acc  <= '0;
            r_phase_step <= '0;
            r_out_valid  <= 1'b0;
            r_sample     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sso_pkg::CFG_DEFAULT_FREQUENCY: r_def_freq   <= i_cfg_data[sso_pkg::FREQ_W-1:0];
                    sso_pkg::CFG_DEFAULT_AMPLITUDE: r_def_amp    <= i_cfg_data[sso_pkg::AMP_W-1:0];
                    sso_pkg::CFG_PHASE_STEP_SCALE:  r_scale      <= i_cfg_data[sso_pkg::SCALE_W-1:0];
                    sso_pkg::CFG_FREQ_SMOOTH_COEFF: r_freq_coeff <= i_cfg_data[sso_pkg::COEFF_W-1:0];
                    sso_pkg::CFG_AMP_SMOOTH_COEFF:  r_amp_coeff  <= i_cfg_data[sso_pkg::COEFF_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        if (i_mode == sso_pkg::MODE_TICK) begin
                            r_state <= ST_FUPD;
                        end else begin
                            r_goal_freq <= i_freq_connected ? i_target_frequency : r_def_freq;
                            r_goal_amp  <= i_amp_connected ? i_target_amplitude : r_def_amp;
                        end
                    end
                end
                ST_FUPD: begin
                    r_cur_freq <= n_cur_freq;
                    r_state    <= ST_PMUL;
                end
                ST_PMUL: begin
                    r_cur_amp <= n_cur_amp;
                    r_state   <= ST_SMUL;
                end
                ST_SMUL: begin
                    r_phase_step <= w_prod[sso_pkg::FRAC_W +: sso_pkg::PHASE_W];
                    r_state      <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_sample    <= n_sample;
                        r_phase_acc <= r_phase_acc + r_phase_step;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

endmodule
`default_nettype wire

/* design/sso_checker.sv */
`default_nettype none
`include "smoothed_sine_oscillator_macros.svh"
module sso_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          o_stall,
    input wire                          i_mode,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire [sso_pkg::SAMPLE_W-1:0]  o_sample
);

    logic w_tick_in;
    logic w_ctrl_in;

    assign w_tick_in = i_valid && !o_stall && (i_mode == sso_pkg::MODE_TICK);
    assign w_ctrl_in = i_valid && !o_stall && (i_mode == sso_pkg::MODE_CONTROL);

    `SSO_ASSERT_NXT(a_tick_busy, w_tick_in, o_stall, "tick item did not make the block busy")
    `SSO_ASSERT_NXT(a_ctrl_free, w_ctrl_in, !o_stall, "control item made the block busy")
    `SSO_ASSERT_IMP(a_tick_result, w_tick_in && !o_valid, ##5 o_valid, "tick item gave no sample")
    `SSO_ASSERT_IMP(a_rose_idle, $rose(o_valid), !o_stall, "sample appeared while still busy")
    `SSO_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sample), "stalled sample changed")

endmodule

bind smoothed_sine_oscillator sso_checker u_sso_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_mode   (i_mode),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_sample (o_sample)
);
`default_nettype wire
